// ===== src/upd_pkg.sv =====
// Shared codes, types and constants of the packet deframer.
package upd_pkg;

  localparam logic [7:0] MAGIC_BYTE = 8'h25;

  localparam logic [15:0] MAX_BODY_LEN_RESET = 16'd256;

  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_TYPE    = 3'd1;
  localparam logic [2:0] PH_LEN_LO  = 3'd2;
  localparam logic [2:0] PH_LEN_HI  = 3'd3;
  localparam logic [2:0] PH_BODY    = 3'd4;
  localparam logic [2:0] PH_DISCARD = 3'd5;

  typedef logic [1:0] event_t;

  localparam event_t EV_ACK    = 2'd0;
  localparam event_t EV_BYTE   = 2'd1;
  localparam event_t EV_ACCEPT = 2'd2;
  localparam event_t EV_REJECT = 2'd3;

  // Framing state carried from one byte to the next.
  typedef struct packed {
    logic [2:0]  phase;
    logic [7:0]  held_type;
    logic [15:0] body_length;
    logic [15:0] bytes_seen;
  } frame_state_t;

  // Up to three results caused by one byte. Data, index and length are
  // shared by the slots and only shown for the event codes that carry them.
  typedef struct packed {
    logic [1:0]       count;
    event_t [2:0]     ev;
    logic [7:0]       cmd;
    logic [7:0]       data;
    logic [15:0]      index;
    logic [15:0]      length;
  } bundle_t;

endpackage

// ===== src/uart_packet_deframer_core.sv =====
// Top level of the length-prefixed packet deframer for received serial bytes.
//
// The block takes one received byte per request and hunts for the magic byte
// 0x25, then reads a type byte and a 16-bit little-endian body length. It
// reports an acknowledgement request after the header; a body no longer than
// max_body_len is passed through with each byte's index and followed by an
// acknowledgement request and an accepted report, while a longer body yields
// one acknowledgement request per discarded byte and a rejected report after
// the last one. A zero length completes the packet with the header. Each
// input byte causes zero to three result requests, and the final one of them
// carries last. A byte's results occupy the single result register until the
// final one is handed out, so bytes are taken at one byte per cycle only while
// each byte causes at most one result and out_stall stays low; a byte with more
// results holds back the bytes behind it. An input register in front lets a
// new byte be taken while results are still waiting to be collected. The
// capacity register is compared only when a header completes, so a write
// affects the next packet; cfg_ready is always high.
module uart_packet_deframer_core import upd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  event_res,
  output logic [7:0]  cmd_type,
  output logic [7:0]  data_byte,
  output logic [15:0] byte_index,
  output logic [15:0] packet_length,
  output logic        last
);

  logic [15:0]  max_body_len;
  logic         in_reg_valid;
  logic [7:0]   in_reg_byte;
  frame_state_t st;
  frame_state_t st_next;
  bundle_t      bundle;
  logic         free;
  logic         advance;
  logic         in_accept;

  // The configuration port never pushes back.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_len <= MAX_BODY_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_body_len <= cfg_data;
    end
  end

  // The held byte moves on when the result register is empty or hands out
  // its final result in this cycle; otherwise the input side is stalled.
  assign advance   = in_reg_valid && free;
  assign in_stall  = in_reg_valid && !free;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_accept) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_reg_byte <= rx_byte;
    end
  end

  upd_parser u_parser (
    .st           (st),
    .rx_byte      (in_reg_byte),
    .max_body_len (max_body_len),
    .st_next      (st_next),
    .bundle       (bundle)
  );

  // Framing state advances exactly when the held byte is processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase       <= PH_HUNT;
      st.held_type   <= 8'h00;
      st.body_length <= 16'd0;
      st.bytes_seen  <= 16'd0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  upd_result_buf u_result_buf (
    .clk           (clk),
    .rst           (rst),
    .load          (advance),
    .bundle_in     (bundle),
    .free          (free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_res     (event_res),
    .cmd_type      (cmd_type),
    .data_byte     (data_byte),
    .byte_index    (byte_index),
    .packet_length (packet_length),
    .last          (last)
  );

`ifndef NO_ASSERTIONS
  a_stall_needs_results: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no results pending");

  a_report_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (event_res == EV_ACCEPT || event_res == EV_REJECT)) |-> last)
    else $error("packet report is not the final result of its byte");

  a_quiet_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res != EV_BYTE) |-> (data_byte == 8'h00 && byte_index == 16'd0))
    else $error("body fields shown on a non-body result");

  a_hunt_exit: assert property (@(posedge clk) disable iff (rst)
    (advance && st.phase == PH_HUNT) |=> (st.phase == PH_HUNT || st.phase == PH_TYPE))
    else $error("left hunting other than to the type byte");
`endif

endmodule

// ===== src/upd_parser.sv =====
// Framing decision for one received byte: next state and the results it causes.
module upd_parser import upd_pkg::*; (
  input  frame_state_t st,
  input  logic [7:0]   rx_byte,
  input  logic [15:0]  max_body_len,
  output frame_state_t st_next,
  output bundle_t      bundle
);

  logic [15:0] len_full;
  logic [15:0] seen_inc;

  assign len_full = {rx_byte, st.body_length[7:0]};
  assign seen_inc = st.bytes_seen + 16'd1;

  always_comb begin
    st_next       = st;
    bundle.count  = 2'd0;
    bundle.ev     = {EV_ACK, EV_ACK, EV_ACK};
    bundle.cmd    = st.held_type;
    bundle.data   = rx_byte;
    bundle.index  = st.bytes_seen;
    bundle.length = st.body_length;
    case (st.phase)
      PH_TYPE: begin
        st_next.held_type = rx_byte;
        st_next.phase     = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        st_next.body_length = {8'h00, rx_byte};
        st_next.phase       = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        st_next.body_length = len_full;
        st_next.bytes_seen  = 16'd0;
        bundle.length       = len_full;
        bundle.count        = 2'd1;
        bundle.ev[0]        = EV_ACK;
        if (len_full == 16'd0) begin
          bundle.count  = 2'd2;
          bundle.ev[1]  = EV_ACCEPT;
          st_next.phase = PH_HUNT;
        end else if (len_full > max_body_len) begin
          st_next.phase = PH_DISCARD;
        end else begin
          st_next.phase = PH_BODY;
        end
      end
      PH_BODY: begin
        st_next.bytes_seen = seen_inc;
        bundle.count       = 2'd1;
        bundle.ev[0]       = EV_BYTE;
        if (seen_inc == st.body_length) begin
          bundle.count  = 2'd3;
          bundle.ev[1]  = EV_ACK;
          bundle.ev[2]  = EV_ACCEPT;
          st_next.phase = PH_HUNT;
        end
      end
      PH_DISCARD: begin
        st_next.bytes_seen = seen_inc;
        bundle.count       = 2'd1;
        bundle.ev[0]       = EV_ACK;
        if (seen_inc == st.body_length) begin
          bundle.count  = 2'd2;
          bundle.ev[1]  = EV_REJECT;
          st_next.phase = PH_HUNT;
        end
      end
      default: begin
        st_next.phase = (rx_byte == MAGIC_BYTE) ? PH_TYPE : PH_HUNT;
      end
    endcase
  end

endmodule

// ===== src/upd_result_buf.sv =====
// Result register that holds one byte's results and hands them out one at a time.
module upd_result_buf import upd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  bundle_t      bundle_in,
  output logic         free,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [1:0]   event_res,
  output logic [7:0]   cmd_type,
  output logic [7:0]   data_byte,
  output logic [15:0]  byte_index,
  output logic [15:0]  packet_length,
  output logic         last
);

  logic    busy;
  logic [1:0] pos;
  bundle_t held;
  event_t  cur_ev;
  logic    fire;
  logic    done_now;

  assign cur_ev   = held.ev[pos];
  assign last     = (pos == held.count - 2'd1);
  assign fire     = busy && !out_stall;
  assign done_now = fire && last;
  assign free     = !busy || done_now;

  assign out_valid     = busy;
  assign event_res     = cur_ev;
  assign cmd_type      = held.cmd;
  assign data_byte     = (cur_ev == EV_BYTE) ? held.data : 8'h00;
  assign byte_index    = (cur_ev == EV_BYTE) ? held.index : 16'd0;
  assign packet_length = (cur_ev == EV_ACCEPT || cur_ev == EV_REJECT) ? held.length : 16'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= 2'd0;
    end else if (load && bundle_in.count != 2'd0) begin
      busy <= 1'b1;
      pos  <= 2'd0;
    end else if (done_now) begin
      busy <= 1'b0;
      pos  <= 2'd0;
    end else if (fire) begin
      pos <= pos + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= bundle_in;
    end
  end

`ifndef NO_ASSERTIONS
  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (pos < held.count))
    else $error("result position beyond result count");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    (load && bundle_in.count != 2'd0) |-> free)
    else $error("new results loaded over pending results");

  a_stalled_hold: assert property (@(posedge clk) disable iff (rst)
    (busy && out_stall) |=> (busy && $stable(pos)))
    else $error("pending result moved while stalled");
`endif

endmodule

// ===== dv/uart_packet_deframer_core_tb.sv =====
// Self-checking testbench for the packet deframer core: random and directed byte streams.
module uart_packet_deframer_core_tb;
  import upd_pkg::*;

  // Cycles that the block may still need after its last result, before it is
  // treated as idle. This covers the input register and the result register.
  localparam int SETTLE_CYCLES = 8;
  // Longest stretch without any accepted request before the run is abandoned.
  localparam int STALL_LIMIT = 2000;
  // Length of the long receiver hold-off that fills up the block.
  localparam int HOLD_CYCLES = 300;
  // Number of random items to aim for across all phases.
  localparam int RANDOM_ITEMS = 272;

  // One expected or observed result request.
  typedef struct {
    event_t      ev;
    logic [7:0]  cmd;
    logic [7:0]  data;
    logic [15:0] index;
    logic [15:0] length;
    logic        last;
  } deframe_result_t;

  // The scoreboard keeps its own copy of the framing state and the capacity
  // register. Each accepted byte is run through the framing rules and the
  // results it causes are queued; each observed result is checked against
  // the oldest queued one.
  class deframe_scoreboard;
    logic [2:0]      phase;
    logic [7:0]      held_type;
    logic [15:0]     body_length;
    logic [15:0]     bytes_seen;
    logic [15:0]     capacity;
    deframe_result_t pending_events[$];
    int              errors;

    function new();
      phase       = PH_HUNT;
      held_type   = '0;
      body_length = '0;
      bytes_seen  = '0;
      capacity    = MAX_BODY_LEN_RESET;
      errors      = 0;
    endfunction

    function void set_capacity(logic [15:0] value);
      capacity = value;
    endfunction

    function void push_event(event_t ev, logic [7:0] data, logic [15:0] index,
                             logic [15:0] length);
      deframe_result_t r;
      r.ev     = ev;
      r.cmd    = held_type;
      r.data   = data;
      r.index  = index;
      r.length = length;
      r.last   = 1'b0;
      pending_events.push_back(r);
    endfunction

    function void note_rx_byte(logic [7:0] b);
      int before_count;
      before_count = pending_events.size();
      case (phase)
        PH_TYPE: begin
          held_type = b;
          phase     = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          body_length = {8'h00, b};
          phase       = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          body_length = {b, body_length[7:0]};
          bytes_seen  = '0;
          push_event(EV_ACK, 8'h00, 16'h0000, 16'h0000);
          if (body_length == 16'h0000) begin
            push_event(EV_ACCEPT, 8'h00, 16'h0000, body_length);
            phase = PH_HUNT;
          end else if (body_length > capacity) begin
            phase = PH_DISCARD;
          end else begin
            phase = PH_BODY;
          end
        end
        PH_BODY: begin
          push_event(EV_BYTE, b, bytes_seen, 16'h0000);
          bytes_seen = bytes_seen + 16'd1;
          if (bytes_seen == body_length) begin
            push_event(EV_ACK, 8'h00, 16'h0000, 16'h0000);
            push_event(EV_ACCEPT, 8'h00, 16'h0000, body_length);
            phase = PH_HUNT;
          end
        end
        PH_DISCARD: begin
          push_event(EV_ACK, 8'h00, 16'h0000, 16'h0000);
          bytes_seen = bytes_seen + 16'd1;
          if (bytes_seen == body_length) begin
            push_event(EV_REJECT, 8'h00, 16'h0000, body_length);
            phase = PH_HUNT;
          end
        end
        default: begin
          phase = (b == MAGIC_BYTE) ? PH_TYPE : PH_HUNT;
        end
      endcase
      if (pending_events.size() > before_count)
        pending_events[pending_events.size() - 1].last = 1'b1;
    endfunction

    function void compare_field(string name, logic [15:0] exp_val, logic [15:0] act_val);
      if (exp_val !== act_val) begin
        $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name,
                 exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_event(deframe_result_t got);
      deframe_result_t exp_r;
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual event %0d cmd %0h",
                 $time, got.ev, got.cmd);
        errors++;
        return;
      end
      exp_r = pending_events.pop_front();
      compare_field("event_res", 16'(exp_r.ev), 16'(got.ev));
      compare_field("cmd_type", 16'(exp_r.cmd), 16'(got.cmd));
      compare_field("data_byte", 16'(exp_r.data), 16'(got.data));
      compare_field("byte_index", exp_r.index, got.index);
      compare_field("packet_length", exp_r.length, got.length);
      compare_field("last", 16'(exp_r.last), 16'(got.last));
    endfunction
  endclass

  // Every input of the block starts at a known value.
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  event_res;
  logic [7:0]  cmd_type;
  logic [7:0]  data_byte;
  logic [15:0] byte_index;
  logic [15:0] packet_length;
  logic        last;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  // Raised by the stimulus to ask the receiver for one long hold-off.
  bit hold_request = 1'b0;
  int items_sent = 0;
  int quiet_cycles = 0;

  deframe_scoreboard sb = new();

  uart_packet_deframer_core DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .event_res     (event_res),
    .cmd_type      (cmd_type),
    .data_byte     (data_byte),
    .byte_index    (byte_index),
    .packet_length (packet_length),
    .last          (last)
  );

  always #6 clk = ~clk;

  // Monitor. All testbench drives use nonblocking assignments at the rising
  // edge and the block's registers update the same way, so the values read
  // here are the ones that were present just before the edge. The watchdog
  // counts cycles in which no request of any channel is accepted.
  always @(posedge clk) begin
    deframe_result_t got;
    if (!rst) begin
      if (in_valid && !in_stall)
        sb.note_rx_byte(rx_byte);
      if (out_valid && !out_stall) begin
        got.ev     = event_res;
        got.cmd    = cmd_type;
        got.data   = data_byte;
        got.index  = byte_index;
        got.length = packet_length;
        got.last   = last;
        sb.check_event(got);
      end
      if (cfg_valid && cfg_ready)
        sb.set_capacity(cfg_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no request accepted for %0d cycles", $time, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Receiver. It stalls at random according to the current phase. When a
  // long hold-off is requested, it keeps stall high for a fixed number of
  // cycles, counted here, so the sender keeps offering bytes until the block
  // backs up and raises its own stall.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_stall <= (recv_stall_pct > 0) && ($urandom_range(99, 0) < recv_stall_pct);
      end
    end
  end

  // Offer one byte and return at the edge where it was accepted. Valid stays
  // high afterward so that back-to-back bytes see no bubble. Stall is
  // sampled at the falling edge, where it has settled.
  task automatic send_byte(input logic [7:0] b);
    logic stalled;
    while ((send_idle_pct > 0) && ($urandom_range(99, 0) < send_idle_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    items_sent++;
  endtask

  // Any byte except the magic one, so the block stays in its hunt state.
  task automatic send_noise();
    logic [7:0] b;
    do b = 8'($urandom_range(255, 0)); while (b == MAGIC_BYTE);
    send_byte(b);
  endtask

  // A complete, well-formed packet with a random body.
  task automatic send_frame(input logic [7:0] kind, input logic [15:0] len);
    send_byte(MAGIC_BYTE);
    send_byte(kind);
    send_byte(len[7:0]);
    send_byte(len[15:8]);
    for (int i = 0; i < int'(len); i++)
      send_byte(8'($urandom_range(255, 0)));
  endtask

  // Stop offering bytes and wait until every expected result has come out.
  // Hunt bytes and the type and low length bytes cause no result, so a few more cycles are allowed
  // for the block to finish with whatever it still holds.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Capacity writes happen only while the block is idle.
  task automatic write_capacity(input logic [15:0] value);
    logic rdy;
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
    cfg_valid <= 1'b0;
  endtask

  // Mixed traffic up to a target count: mostly well-formed packets with
  // random content, plus bursts of noise. Lengths are mostly short, with now and then
  // one right at or just past the capacity when it is at most 300, or of 20 to 40 bytes otherwise.
  task automatic random_traffic(input int target, input logic [15:0] cap);
    int pick;
    int len;
    while (items_sent < target) begin
      pick = $urandom_range(99, 0);
      if (pick < 15) begin
        repeat ($urandom_range(3, 1)) send_noise();
      end else begin
        if (pick < 70)
          len = $urandom_range(8, 0);
        else if (pick < 95)
          len = $urandom_range(24, 0);
        else if (cap <= 300)
          len = int'(cap) + $urandom_range(1, 0);
        else
          len = $urandom_range(40, 20);
        send_frame(8'($urandom_range(255, 0)), 16'(len));
      end
    end
  endtask

  initial begin
    int phase_target;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part, no idling on either side, capacity at its reset value.
    send_byte(8'h00);
    send_byte(8'hFF);
    // Zero length completes the packet with the header itself.
    send_frame(8'hFF, 16'h0000);
    // The magic byte as type and inside the body.
    send_byte(MAGIC_BYTE);
    send_byte(MAGIC_BYTE);
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(MAGIC_BYTE);
    send_byte(8'hFF);
    send_frame(8'h00, 16'h0001);
    // With no capacity at all, any body is discarded and rejected, while an
    // empty packet is still accepted.
    write_capacity(16'h0000);
    send_frame(8'h7E, 16'h0002);
    send_frame(8'h81, 16'h0000);

    // Phase without idling, largest capacity. A long receiver hold-off while
    // a packet streams in makes the block fill up and stall its input.
    write_capacity(16'hFFFF);
    hold_request = 1'b1;
    send_frame(8'h5A, 16'd40);
    phase_target = items_sent + RANDOM_ITEMS / 4;
    random_traffic(phase_target, 16'hFFFF);

    // Sender idles often; a small capacity so many packets get rejected.
    write_capacity(16'd4);
    send_idle_pct  = 61;
    recv_stall_pct = 0;
    phase_target = items_sent + RANDOM_ITEMS / 4;
    random_traffic(phase_target, 16'd4);

    // Receiver stalls often; a capacity of sixteen, with bodies at its edge.
    write_capacity(16'h0010);
    send_idle_pct  = 0;
    recv_stall_pct = 61;
    send_frame(8'h3C, 16'h0010);
    phase_target = items_sent + RANDOM_ITEMS / 4;
    random_traffic(phase_target, 16'h0010);

    // Both sides idle; a random small capacity.
    write_capacity(16'($urandom_range(12, 1)));
    send_idle_pct  = 24;
    recv_stall_pct = 24;
    phase_target = items_sent + RANDOM_ITEMS / 4;
    random_traffic(phase_target, sb.capacity);

    wait_idle();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (sb.pending_events.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time,
               sb.pending_events.size());
      sb.errors += sb.pending_events.size();
    end
    if (sb.errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
